>>> sv/tfl_pkg.sv
package tfl_pkg;

    localparam int PAGE_W     = 20;
    localparam int FRAME_W    = 20;
    localparam int IU_W       = 5;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [IU_W-1:0] IU_RESET = IU_W'(16);

    localparam logic [CFG_ADDR_W-1:0] REG_ENTRIES_IN_USE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_REPL_MODE      = CFG_ADDR_W'(1);

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                cmd;
        logic [PAGE_W-1:0]   page_number;
        logic [FRAME_W-1:0]  frame_number;
    } t_req;

    typedef struct packed {
        logic                hit;
        logic [FRAME_W-1:0]  found_frame;
        logic                evicted;
        logic [PAGE_W-1:0]   evicted_page;
    } t_res;

    typedef struct packed {
        logic [PAGE_W-1:0]   page_number;
        logic [FRAME_W-1:0]  frame_number;
    } t_entry;

    typedef struct packed {
        logic                cmp_en;
        logic                shift_en;
        logic [PAGE_W-1:0]   cmp_page;
    } t_cell_ctl;

endpackage

>>> sv/tfl_cell.sv
module tfl_cell
    import tfl_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_prev,
    output t_entry    o_entry,
    output logic      o_match
);

    t_entry r_entry;
    logic   r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_match <= (r_entry.page_number == i_ctl.cmp_page);
        end
        if (i_ctl.shift_en) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

>>> sv/tlb_fifo_lru_replacement.sv
// Fully associative translation buffer kept as an ordered row of entry cells,
// the most recent entry in the front cell.
// A transaction is accepted at a rising edge where start is high and busy is
// low. Its fields are cmd (lookup, insert, flush, no-op), page and frame.
// At that edge every cell compares its page with the request and holds the
// result. In the following cycle the first valid match or the tail is chosen,
// the result is registered and the cells shift toward the tail as needed.
// The result is registered into o_res at the end of that cycle, and o_done is
// high with it for exactly one cycle; the receiver cannot stall it.
// A new transaction is not accepted until the select and shift cycle that
// follows the registered compare in the cells is over.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_addr, i_cfg_data)
// is always ready. Index 0 sets the number of entries in use and index 1 the
// replacement mode (0 FIFO, 1 LRU). Write it only while the block is idle.
// Synchronous reset empties the buffer, sets 16 entries in use and FIFO mode.
module tlb_fifo_lru_replacement
    import tfl_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_req                  i_req,
    output logic                  o_done,
    output t_res                  o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int KW = (CW > IU_W) ? CW : IU_W;
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    function automatic logic [KW-1:0] cap_of(input logic [IU_W-1:0] in_use);
        logic [KW-1:0] v;
        v = KW'(in_use);
        return (v > KW'(MAX_ENTRIES)) ? KW'(MAX_ENTRIES) : v;
    endfunction

    t_state              r_state;
    logic [KW-1:0]       r_count;
    logic [IU_W-1:0]     r_in_use;
    logic                r_mode;
    t_cmd                r_cmd;
    logic [PAGE_W-1:0]   r_page;
    logic [FRAME_W-1:0]  r_frame;

    logic                   w_accept;
    logic [KW-1:0]          w_cap;
    t_entry                 w_entry [MAX_ENTRIES];
    t_cell_ctl              w_ctl   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_match;
    logic [MAX_ENTRIES-1:0] w_valid;
    logic [MAX_ENTRIES-1:0] w_hitv;
    logic [MAX_ENTRIES-1:0] w_first;
    logic [MAX_ENTRIES-1:0] w_le_mask;
    logic [MAX_ENTRIES-1:0] w_shift;
    logic                   w_hit;
    logic [FRAME_W-1:0]     w_found;
    logic                   w_full;
    logic [KW-1:0]          w_upto;
    logic [IW-1:0]          w_tail_idx;
    logic                   w_ins_ok;
    logic                   w_lru_move;
    t_entry                 w_front;
    t_res                   n_res;
    logic [KW-1:0]          n_count;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_cap       = cap_of(r_in_use);

    assign w_hitv    = w_match & w_valid;
    assign w_hit     = |w_hitv;
    assign w_first   = w_hitv & (~w_hitv + MAX_ENTRIES'(1));
    assign w_le_mask = w_first | (w_first - MAX_ENTRIES'(1));

    assign w_full     = (r_count >= w_cap);
    assign w_upto     = w_full ? (w_cap - KW'(1)) : r_count;
    assign w_tail_idx = IW'(w_cap - KW'(1));
    assign w_ins_ok   = (r_cmd == CMD_INSERT) && (w_cap != '0);
    assign w_lru_move = (r_cmd == CMD_LOOKUP) && r_mode && w_hit;

    assign w_front.page_number  = r_page;
    assign w_front.frame_number = (r_cmd == CMD_INSERT) ? r_frame : w_found;

    always_comb begin
        w_found = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_valid[i] = (KW'(i) < r_count);
            if (w_first[i]) begin
                w_found = w_found | w_entry[i].frame_number;
            end
            if (w_ins_ok) begin
                w_shift[i] = (KW'(i) <= w_upto);
            end else if (w_lru_move) begin
                w_shift[i] = w_le_mask[i];
            end else begin
                w_shift[i] = 1'b0;
            end
        end
    end

    generate
        for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
            assign w_ctl[g].cmp_en   = w_accept;
            assign w_ctl[g].shift_en = (r_state == S_EXEC) && w_shift[g];
            assign w_ctl[g].cmp_page = i_req.page_number;
            if (g == 0) begin : g_head
                tfl_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (w_ctl[g]),
                    .i_prev  (w_front),
                    .o_entry (w_entry[g]),
                    .o_match (w_match[g])
                );
            end else begin : g_body
                tfl_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (w_ctl[g]),
                    .i_prev  (w_entry[g-1]),
                    .o_entry (w_entry[g]),
                    .o_match (w_match[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_res   = '0;
        n_count = r_count;
        case (r_cmd)
            CMD_LOOKUP: begin
                n_res.hit         = w_hit;
                n_res.found_frame = w_found;
            end
            CMD_INSERT: begin
                if (w_cap != '0) begin
                    n_res.evicted = w_full;
                    if (w_full) begin
                        n_res.evicted_page = w_entry[w_tail_idx].page_number;
                    end
                    n_count = w_upto + KW'(1);
                end
            end
            CMD_FLUSH: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_done   <= 1'b0;
            r_count  <= '0;
            r_in_use <= IU_RESET;
            r_mode   <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    REG_ENTRIES_IN_USE: begin
                        r_in_use <= i_cfg_data[IU_W-1:0];
                        if (r_count > cap_of(i_cfg_data[IU_W-1:0])) begin
                            r_count <= cap_of(i_cfg_data[IU_W-1:0]);
                        end
                    end
                    REG_REPL_MODE: begin
                        r_mode <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                        r_cmd   <= i_req.cmd;
                        r_page  <= i_req.page_number;
                        r_frame <= i_req.frame_number;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    o_done  <= 1'b1;
                    o_res   <= n_res;
                    r_count <= n_count;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy did not rise after an accepted transaction");

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_EXEC))
        else $error("result strobe without a preceding execute cycle");

    a_count_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= w_cap)
        else $error("entry count exceeds capacity");

    a_hit_only_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.hit) |-> (r_cmd == CMD_LOOKUP))
        else $error("hit reported for a command other than lookup");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.evicted) |-> ((r_cmd == CMD_INSERT) && (r_count == w_cap)))
        else $error("eviction reported without a full buffer after insert");

endmodule
